// ----- rtl/core/fmtp_pkg.sv -----
`timescale 1ns / 1ps
// Package with the shared codes, widths and period functions of the FM timer pair.
package fmtp_pkg;

	// Action codes carried by a request transfer.
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// Register numbers that the latch can name.
	localparam logic [7:0] REG_TIMER_A_HI = 8'h24;
	localparam logic [7:0] REG_TIMER_A_LO = 8'h25;
	localparam logic [7:0] REG_TIMER_B    = 8'h26;
	localparam logic [7:0] REG_CONTROL    = 8'h27;

	// Flag clear bits in the control register data.
	localparam int unsigned CLR_A_BIT = 4;
	localparam int unsigned CLR_B_BIT = 5;

	// Defaults for the top level parameters.
	localparam int unsigned TICK_STEP_DEF   = 64;
	localparam int unsigned TICKER_BITS_DEF = 24;

	// Widest period is 288 * 256 = 73728, which needs 17 bits.
	localparam int unsigned PERIOD_W = 17;

	typedef logic [PERIOD_W-1:0] period_t;

	function automatic period_t period_a(input logic [9:0] a);
		period_a = period_t'(18) * (period_t'(1024) - period_t'(a));
	endfunction

	function automatic period_t period_b(input logic [7:0] b);
		period_b = period_t'(288) * (period_t'(256) - period_t'(b));
	endfunction

endpackage

// ----- rtl/core/fmtp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses of the FM timer pair.
interface fmtp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] address;
	logic [7:0] data;

	modport source(output valid, action, address, data, input ready);
	modport sink(input valid, action, address, data, output ready);
endinterface

interface fmtp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [1:0] flags_now;

	modport source(output valid, read_data, flags_now, input ready);
	modport sink(input valid, read_data, flags_now, output ready);
endinterface

// ----- rtl/core/fmtp_ticker.sv -----
`timescale 1ns / 1ps
// One saturating elapsed-time ticker with its period check.
module fmtp_ticker #(
	parameter int unsigned TICK_STEP   = 64,
	parameter int unsigned TICKER_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     tick,
	input  logic [fmtp_pkg::PERIOD_W-1:0] period,
	output logic                     hit
);
	import fmtp_pkg::*;

	logic [TICKER_BITS-1:0] ticker_q;
	logic [TICKER_BITS:0]   sum;
	logic [TICKER_BITS-1:0] sat;
	logic [TICKER_BITS-1:0] period_ext;

	assign sum        = {1'b0, ticker_q} + (TICKER_BITS+1)'(TICK_STEP);
	assign sat        = sum[TICKER_BITS] ? {TICKER_BITS{1'b1}} : sum[TICKER_BITS-1:0];
	assign period_ext = TICKER_BITS'(period);
	assign hit        = (sat >= period_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticker_q <= '0;
		end else if (tick) begin
			// The period is taken off once when the ticker reaches it.
			ticker_q <= hit ? (sat - period_ext) : sat;
		end
	end

endmodule

// ----- rtl/core/fm_chip_timer_pair_top.sv -----
`timescale 1ns / 1ps
// Top level of the FM sound chip timer pair (timers A and B with their flags).
//
// This block takes one request transfer per cycle (a bus write, a bus read
// or one scanline tick) and returns exactly one response transfer for each
// from a single output register that is loaded on acceptance. A request is
// taken whenever that output register is empty or is being emptied in the
// same cycle, so with a response sink that is always ready the block
// sustains one item per clock. All state (bank latches, timer values,
// tickers and flags) updates at the edge that accepts the request, so the
// next request already sees it. A tick adds TICK_STEP to both tickers,
// saturating at the top of a TICKER_BITS wide counter; a ticker that reaches
// its period raises its flag and the period is subtracted once. Timer A's
// period is 18*(1024-A) and timer B's is 288*(256-B), both derived from the
// timer values with constant multiplies. The response carries the status
// flags on a read at an even address (zero otherwise) and the flags as they
// stand after the item.
module fm_chip_timer_pair_top #(
	parameter int unsigned TICK_STEP   = fmtp_pkg::TICK_STEP_DEF,
	parameter int unsigned TICKER_BITS = fmtp_pkg::TICKER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fmtp_req_if.sink          req,
	fmtp_rsp_if.source        rsp
);
	import fmtp_pkg::*;

	// Architectural state.
	logic [7:0] bank_latch_q [2];
	logic [7:0] timer_a_upper_q;
	logic [1:0] timer_a_lower_q;
	logic [7:0] timer_b_value_q;
	logic [1:0] flags_q;

	// Output register.
	logic       rsp_valid_q;
	logic [7:0] read_data_q;
	logic [1:0] flags_now_q;

	logic       accept;
	logic       bank;
	logic [7:0] latch_sel;
	logic       is_write;
	logic       is_data_write;
	logic       do_tick;
	logic       hit_a;
	logic       hit_b;
	period_t    per_a;
	period_t    per_b;
	logic [1:0] flags_next;
	logic [7:0] read_next;

	// A new request is taken when the output register is free or drains now.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign bank          = req.address[1];
	assign latch_sel     = bank_latch_q[bank];
	assign is_write      = (req.action == ACT_WRITE);
	assign is_data_write = is_write && req.address[0];
	assign do_tick       = accept && (req.action == ACT_TICK);

	assign per_a = period_a({timer_a_upper_q, timer_a_lower_q});
	assign per_b = period_b(timer_b_value_q);

	fmtp_ticker #(
		.TICK_STEP  (TICK_STEP),
		.TICKER_BITS(TICKER_BITS)
	) u_ticker_a (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (do_tick),
		.period(per_a),
		.hit   (hit_a)
	);

	fmtp_ticker #(
		.TICK_STEP  (TICK_STEP),
		.TICKER_BITS(TICKER_BITS)
	) u_ticker_b (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (do_tick),
		.period(per_b),
		.hit   (hit_b)
	);

	// Flags and read data that follow from the current request.
	always_comb begin
		flags_next = flags_q;
		read_next  = '0;
		unique case (req.action)
			ACT_WRITE: begin
				// The control register clears flags in either bank.
				if (req.address[0] && (latch_sel == REG_CONTROL)) begin
					if (req.data[CLR_A_BIT]) begin
						flags_next[0] = 1'b0;
					end
					if (req.data[CLR_B_BIT]) begin
						flags_next[1] = 1'b0;
					end
				end
			end
			ACT_READ: begin
				if (!req.address[0]) begin
					read_next = {6'b0, flags_q};
				end
			end
			ACT_TICK: begin
				flags_next = flags_q | {hit_b, hit_a};
			end
			default: begin
				// The unused action changes nothing.
			end
		endcase
	end

	// Bank latches, timer values and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_latch_q[0] <= '0;
			bank_latch_q[1] <= '0;
			timer_a_upper_q <= '0;
			timer_a_lower_q <= '0;
			timer_b_value_q <= '0;
			flags_q         <= '0;
		end else if (accept) begin
			flags_q <= flags_next;
			if (is_write && !req.address[0]) begin
				bank_latch_q[bank] <= req.data;
			end
			// Timer registers exist in bank 0 only.
			if (is_data_write && !bank) begin
				if (latch_sel == REG_TIMER_A_HI) begin
					timer_a_upper_q <= req.data;
				end
				if (latch_sel == REG_TIMER_A_LO) begin
					timer_a_lower_q <= req.data[1:0];
				end
				if (latch_sel == REG_TIMER_B) begin
					timer_b_value_q <= req.data;
				end
			end
		end
	end

	// Response register: filled on acceptance, emptied on a response transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= read_next;
			flags_now_q <= flags_next;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.flags_now = flags_now_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the FM timer pair: directed table, random traffic and a tick run.
module tb_top;
	import fmtp_pkg::*;

	// The block is built with its default tick step and ticker width, and the
	// status predictor below works at those same sizes.
	localparam int unsigned STEP = TICK_STEP_DEF;
	localparam int unsigned BITS = TICKER_BITS_DEF;

	// The package names no code for the fourth action value; the block must treat it as a no-op.
	localparam logic [1:0] ACT_IDLE = 2'd3;

	// Status flag positions as they appear in read_data and flags_now.
	localparam logic [1:0] FLAG_A = 2'b01;
	localparam logic [1:0] FLAG_B = 2'b10;

	// The slowest correct run is about 710 items that each may see a gap on
	// the sender side and a stall on the response side. The limit is set far above that.
	localparam int unsigned CYCLE_LIMIT = 200_000;

	typedef logic [BITS-1:0] ticker_t;
	localparam ticker_t TICKER_TOP = '1;

	// One response transfer as the predictor sees it.
	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] flags_now;
	} status_t;

	// One request transfer, with an optional hand-written expectation.
	typedef struct packed {
		logic [1:0] action;
		logic [1:0] address;
		logic [7:0] data;
		logic       typed;
		logic [7:0] rd;
		logic [1:0] flags;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	fmtp_req_if req_ch();
	fmtp_rsp_if rsp_ch();

	fm_chip_timer_pair_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #10 clk = ~clk;

	// Shadow copy of the block's state, updated once per accepted request.
	logic [7:0] latch_q [2];
	logic [7:0] a_hi;
	logic [1:0] a_lo;
	logic [7:0] b_val;
	ticker_t    tick_a;
	ticker_t    tick_b;
	logic [1:0] flags;

	// Responses still owed by the block, oldest first.
	status_t status_due [$];

	int errors = 0;
	int cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;

	// Directed part. The first twelve rows carry an expectation that follows
	// directly from reset and the extreme timer values; the rest are checked
	// against the predictor. Rows walk through: reads at both address kinds,
	// the unused action, timer A at its shortest period, timer B at its
	// shortest period, bank 1 writes to timer registers (ignored), flag clears
	// from either bank, and data for an unknown register (dropped).
	stim_row_t dir_rows [0:24] = '{
		'{ACT_READ,  2'd0, 8'h00, 1'b1, 8'h00, 2'b00},
		'{ACT_READ,  2'd1, 8'hFF, 1'b1, 8'h00, 2'b00},
		'{ACT_IDLE,  2'd3, 8'hFF, 1'b1, 8'h00, 2'b00},
		'{ACT_TICK,  2'd0, 8'h00, 1'b1, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd0, 8'h24, 1'b1, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd1, 8'hFF, 1'b1, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd0, 8'h25, 1'b1, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd1, 8'hFF, 1'b1, 8'h00, 2'b00},
		'{ACT_TICK,  2'd3, 8'hAA, 1'b1, 8'h00, 2'b01},
		'{ACT_READ,  2'd0, 8'h55, 1'b1, 8'h01, 2'b01},
		'{ACT_WRITE, 2'd0, 8'h26, 1'b1, 8'h00, 2'b01},
		'{ACT_WRITE, 2'd1, 8'hFF, 1'b1, 8'h00, 2'b01},
		'{ACT_TICK,  2'd1, 8'h00, 1'b0, 8'h00, 2'b00},
		'{ACT_TICK,  2'd2, 8'h00, 1'b0, 8'h00, 2'b00},
		'{ACT_TICK,  2'd0, 8'h00, 1'b0, 8'h00, 2'b00},
		'{ACT_READ,  2'd3, 8'h00, 1'b0, 8'h00, 2'b00},
		'{ACT_READ,  2'd2, 8'h00, 1'b0, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd2, 8'h24, 1'b0, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd3, 8'h00, 1'b0, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd2, 8'h27, 1'b0, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd3, 8'h10, 1'b0, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd0, 8'h27, 1'b0, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd1, 8'h20, 1'b0, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd0, 8'h80, 1'b0, 8'h00, 2'b00},
		'{ACT_WRITE, 2'd1, 8'h00, 1'b0, 8'h00, 2'b00}
	};

	// One tick of a ticker: add the step, clamp at the top of the counter, and
	// take one period off when the period is reached.
	function automatic ticker_t step_ticker(input ticker_t cnt, input int unsigned period,
			output logic hit);
		logic [BITS:0] sum;
		logic [BITS:0] per;
		per = (BITS+1)'(period);
		sum = {1'b0, cnt} + (BITS+1)'(STEP);
		if (sum > {1'b0, TICKER_TOP}) begin
			sum = {1'b0, TICKER_TOP};
		end
		hit = (sum >= per);
		if (hit) begin
			sum = sum - per;
		end
		return sum[BITS-1:0];
	endfunction

	// Status predictor: applies one request to the shadow state and returns
	// the response the block owes for it.
	function automatic status_t predict_status(input logic [1:0] act, input logic [1:0] addr,
			input logic [7:0] value);
		status_t     res;
		logic        bank;
		logic        hit;
		int unsigned per_a;
		int unsigned per_b;
		res  = '0;
		bank = addr[1];
		case (act)
			ACT_WRITE: begin
				if (!addr[0]) begin
					latch_q[bank] = value;
				end else begin
					case (latch_q[bank])
						REG_TIMER_A_HI: if (!bank) a_hi = value;
						REG_TIMER_A_LO: if (!bank) a_lo = value[1:0];
						REG_TIMER_B:    if (!bank) b_val = value;
						REG_CONTROL: begin
							if (value[CLR_A_BIT]) flags = flags & ~FLAG_A;
							if (value[CLR_B_BIT]) flags = flags & ~FLAG_B;
						end
						default: ;
					endcase
				end
			end
			ACT_READ: begin
				if (!addr[0]) begin
					res.read_data = {6'b0, flags};
				end
			end
			ACT_TICK: begin
				per_a  = 18 * (1024 - {a_hi, a_lo});
				per_b  = 288 * (256 - b_val);
				tick_a = step_ticker(tick_a, per_a, hit);
				if (hit) flags = flags | FLAG_A;
				tick_b = step_ticker(tick_b, per_b, hit);
				if (hit) flags = flags | FLAG_B;
			end
			default: ;
		endcase
		res.flags_now = flags;
		return res;
	endfunction

	function automatic stim_row_t mk(input logic [1:0] act, input logic [1:0] addr,
			input logic [7:0] value);
		mk = '{act, addr, value, 1'b0, 8'h00, 2'b00};
	endfunction

	// Presents one request and holds it until the block takes it. Before the
	// request the sender may go quiet for a burst; the payload wiggles during
	// the gap so that the block is seen to ignore it while valid is low.
	// Valid is left high after the transfer so that back-to-back requests
	// keep it high between them.
	task automatic send_item(input stim_row_t row);
		status_t want;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req_ch.valid   <= 1'b0;
			req_ch.action  <= 2'($urandom);
			req_ch.address <= 2'($urandom);
			req_ch.data    <= 8'($urandom);
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.action  <= row.action;
		req_ch.address <= row.address;
		req_ch.data    <= row.data;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		// The transfer happened at this edge: the predictor runs now, so its
		// state matches what the block holds for the next request.
		want = predict_status(row.action, row.address, row.data);
		if (row.typed) begin
			want.read_data = row.rd;
			want.flags_now = row.flags;
		end
		status_due.push_back(want);
	endtask

	// Drops valid right after the last transfer and holds off until every
	// owed response has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
	endtask

	// Picks a fresh idling mix for both sides; a zero share gives stretches
	// with no idling at all.
	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 8;
			default: return 30;
		endcase
	endfunction

	// Random traffic. Most of it is register programming done the way
	// software does it (a latch write followed by a data write), with timer
	// values leaning towards short periods so that both flags fire often.
	// Ticks and reads fill the rest, with some stray writes and unused
	// actions as noise.
	task automatic run_random(input int count, input bit quiet);
		int         sent;
		int         pick;
		logic       bank;
		logic [7:0] reg_num;
		logic [7:0] val;
		sent = 0;
		while (sent < count) begin
			if (quiet) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else if ($urandom_range(0, 49) == 0) begin
				gap_pct   = pick_pct();
				stall_pct = pick_pct();
			end
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				bank = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 4) == 0) begin
					reg_num = 8'($urandom);
				end else begin
					reg_num = REG_TIMER_A_HI + 8'($urandom_range(0, 3));
				end
				case (reg_num)
					REG_TIMER_A_HI: val = ($urandom_range(0, 2) != 0) ?
						8'($urandom_range(8'hF0, 8'hFF)) : 8'($urandom);
					REG_TIMER_B:    val = ($urandom_range(0, 2) != 0) ?
						8'($urandom_range(8'hE8, 8'hFF)) : 8'($urandom);
					default:        val = 8'($urandom);
				endcase
				send_item(mk(ACT_WRITE, {bank, 1'b0}, reg_num));
				send_item(mk(ACT_WRITE, {bank, 1'b1}, val));
				sent += 2;
			end else begin
				if (pick < 75) begin
					send_item(mk(ACT_TICK, 2'($urandom), 8'($urandom)));
				end else if (pick < 90) begin
					send_item(mk(ACT_READ, 2'($urandom), 8'($urandom)));
				end else if (pick < 95) begin
					send_item(mk(ACT_WRITE, 2'($urandom), 8'($urandom)));
				end else begin
					send_item(mk(ACT_IDLE, 2'($urandom), 8'($urandom)));
				end
				sent += 1;
			end
		end
	endtask

	// Response sink: ready drops in bursts at a rate set by stall_pct, and
	// stays high when that rate is zero.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 13);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Response checker: every transfer on the response channel is matched
	// against the oldest owed response, field by field.
	always @(posedge clk) begin : rsp_check
		status_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (status_due.size() == 0) begin
				$display("%0t: response with nothing owed: read_data %0h flags_now %0b",
					$time, rsp_ch.read_data, rsp_ch.flags_now);
				errors++;
			end else begin
				want = status_due.pop_front();
				if (rsp_ch.read_data !== want.read_data) begin
					$display("%0t: read_data expected %0h actual %0h",
						$time, want.read_data, rsp_ch.read_data);
					errors++;
				end
				if (rsp_ch.flags_now !== want.flags_now) begin
					$display("%0t: flags_now expected %0b actual %0b",
						$time, want.flags_now, rsp_ch.flags_now);
					errors++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		// Every input is known from time zero, and the shadow state starts
		// where reset leaves the block.
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.action  = ACT_WRITE;
		req_ch.address = 2'd0;
		req_ch.data    = 8'h00;
		rsp_ch.ready   = 1'b0;
		latch_q[0]     = 8'h00;
		latch_q[1]     = 8'h00;
		a_hi           = 8'h00;
		a_lo           = 2'b00;
		b_val          = 8'h00;
		tick_a         = '0;
		tick_b         = '0;
		flags          = 2'b00;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, with light idling on both sides.
		gap_pct   = 20;
		stall_pct = 20;
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i]);
		end

		// The sender holds back until the block has answered everything, once after
		// the table, once in the middle of the random traffic and once after it.
		wait_drained();
		run_random(300, 1'b0);
		wait_drained();
		run_random(300, 1'b0);
		wait_drained();

		// From here on neither side idles. Timer A goes to its shortest
		// period (18), which is below the tick step, so every tick sets its
		// flag and its ticker climbs by 46 per tick.
		gap_pct   = 0;
		stall_pct = 0;
		send_item(mk(ACT_WRITE, 2'd0, REG_TIMER_A_HI));
		send_item(mk(ACT_WRITE, 2'd1, 8'hFF));
		send_item(mk(ACT_WRITE, 2'd0, REG_TIMER_A_LO));
		send_item(mk(ACT_WRITE, 2'd1, 8'hFF));
		repeat (40) send_item(mk(ACT_TICK, 2'($urandom), 8'($urandom)));
		send_item(mk(ACT_READ, 2'd0, 8'h00));

		// A short tail of random traffic at full rate.
		run_random(40, 1'b1);

		wait_drained();
		// Waiting on past the drain lets any stray response from the block's output
		// register show up in the checker.
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/fmtp_pkg.sv
rtl/core/fmtp_if.sv
rtl/core/fmtp_ticker.sv
rtl/core/fm_chip_timer_pair_top.sv
tb/tb_top.sv
